[rtl/core/gph_pkg.sv]
// gph_pkg: shared types, constants and the gf(2^128) digit step for the polynomial hash
// used by gph_mul, gf128_polynomial_hash and gph_checker; no dependencies
package gph_pkg;

  localparam int LEN_WIDTH_DEF = 32;
  localparam int BLK_W         = 128;
  localparam int DIGIT_W       = 8;
  localparam int DIGITS        = BLK_W / DIGIT_W;
  localparam int DCNT_W        = $clog2(DIGITS);
  localparam int CFG_IDX_W     = 1;
  localparam logic [7:0] RED_POLY = 8'hE1;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_HI = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LO = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BLOCK,
    ST_LENGTH,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic             done;
    logic [BLK_W-1:0] product;
  } mul_rsp_t;

  typedef struct packed {
    logic [BLK_W-1:0] z;
    logic [BLK_W-1:0] w;
  } mul_pair_t;

  // eight key bits, msb first, of the bit-reflected shift-and-add multiply
  function automatic mul_pair_t gf_digit(input mul_pair_t cur, input logic [DIGIT_W-1:0] kd);
    mul_pair_t  p;
    logic       lsb;
    p = cur;
    for (int i = 0; i < DIGIT_W; i++) begin
      if (kd[DIGIT_W-1-i]) begin
        p.w = p.w ^ p.z;
      end
      lsb = p.z[0];
      p.z = p.z >> 1;
      if (lsb) begin
        p.z[BLK_W-1 -: 8] = p.z[BLK_W-1 -: 8] ^ RED_POLY;
      end
    end
    return p;
  endfunction

endpackage

[rtl/core/gph_mul.sv]
// gph_mul: digit-serial gf(2^128) multiplier, one key byte per cycle
// depends on gph_pkg
module gph_mul (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [gph_pkg::BLK_W-1:0]  x,
  input  logic [gph_pkg::BLK_W-1:0]  key,
  output gph_pkg::mul_rsp_t          rsp
);

  gph_pkg::mul_pair_t               pair_r, pair_nxt, step;
  logic [gph_pkg::BLK_W-1:0]        key_r, key_nxt;
  logic [gph_pkg::DCNT_W-1:0]       cnt_r, cnt_nxt;
  logic                             run_r, run_nxt;
  logic                             done_r, done_nxt;

  assign step = gph_pkg::gf_digit(pair_r, key_r[gph_pkg::BLK_W-1 -: gph_pkg::DIGIT_W]);

  always_comb begin
    pair_nxt = pair_r;
    key_nxt  = key_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      pair_nxt.z = x;
      pair_nxt.w = '0;
      key_nxt    = key;
      cnt_nxt    = '0;
      run_nxt    = 1'b1;
    end else if (run_r) begin
      pair_nxt = step;
      key_nxt  = key_r << gph_pkg::DIGIT_W;
      cnt_nxt  = cnt_r + 1'b1;
      if (cnt_r == gph_pkg::DCNT_W'(gph_pkg::DIGITS - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    pair_r <= pair_nxt;
    key_r  <= key_nxt;
    cnt_r  <= cnt_nxt;
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  assign rsp.done    = done_r;
  assign rsp.product = pair_r.w;

endmodule

[rtl/core/gf128_polynomial_hash.sv]
// gf128_polynomial_hash: keyed polynomial hash over bit-reflected gf(2^128)
// depends on gph_pkg and gph_mul
//
// usage
//   key must be written via the cfg channel (index 0 upper half, 1 lower half)
//   only while idle; the block does not enforce this. cfg_ready is always high.
//   message blocks enter on the in_ channel, one request per 128-bit block,
//   byte 0 in the top bits of in_block_hi; bytes past in_valid_bytes are zeroed.
//   in_last_block closes the message: the bit length is folded in and one
//   digest request leaves on the out_ channel.
//   in_stall stays high after a block is accepted, so a new block waits for the
//   launch, the digit-serial multiplier (one key byte per cycle) and writeback.
//   a last block runs a second multiply for the length word and holds in_stall
//   until the digest enters the output register, which waits for it to be free.
//   the output register holds a waiting digest, so the next message may start
//   while it is stalled; a second digest waits in the core until it drains.
//   synchronous reset clears the accumulator, count, flag, key and out_valid.
module gf128_polynomial_hash #(
  parameter int LEN_WIDTH = gph_pkg::LEN_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [63:0]                    in_block_hi,
  input  logic [63:0]                    in_block_lo,
  input  logic [4:0]                     in_valid_bytes,
  input  logic                           in_last_block,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [63:0]                    out_digest_hi,
  output logic [63:0]                    out_digest_lo,
  output logic                           out_length_overflow,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [gph_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [63:0]                    cfg_data
);

  localparam int CNT_W = LEN_WIDTH - 3;
  localparam int BW    = gph_pkg::BLK_W;

  gph_pkg::state_t      state_r, state_nxt;
  logic [63:0]          key_hi_r, key_lo_r;
  logic [BW-1:0]        acc_r, acc_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 sat_r, sat_nxt;
  logic                 last_r, last_nxt;
  logic                 ov_r, ov_nxt;
  logic [63:0]          dhi_r, dhi_nxt, dlo_r, dlo_nxt;
  logic                 ovl_r, ovl_nxt;

  logic                 accept, out_free, mul_start, sel_len;
  logic [4:0]           vb;
  logic [BW-1:0]        mask, blk, mul_x;
  logic [CNT_W:0]       sum;
  logic [63:0]          len_word;
  gph_pkg::mul_rsp_t    rsp;

  gph_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .x     (mul_x),
    .key   ({key_hi_r, key_lo_r}),
    .rsp   (rsp)
  );

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;
  assign out_free  = !ov_r || !out_stall;

  assign vb = (in_valid_bytes > 5'd16) ? 5'd16 : in_valid_bytes;
  always_comb begin
    mask = '0;
    for (int j = 0; j < 16; j++) begin
      mask[BW-1-8*j -: 8] = (5'(j) < vb) ? 8'hFF : 8'h00;
    end
  end
  assign blk      = {in_block_hi, in_block_lo} & mask;
  assign sum      = {1'b0, cnt_r} + (CNT_W+1)'(vb);
  assign len_word = 64'({cnt_r, 3'b000});

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gph_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = gph_pkg::ST_BLOCK;
      end
      gph_pkg::ST_BLOCK: begin
        if (rsp.done) state_nxt = last_r ? gph_pkg::ST_LENGTH : gph_pkg::ST_IDLE;
      end
      gph_pkg::ST_LENGTH: begin
        if (rsp.done) state_nxt = gph_pkg::ST_DONE;
      end
      gph_pkg::ST_DONE: begin
        if (out_free) state_nxt = gph_pkg::ST_IDLE;
      end
      default: state_nxt = gph_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = 1'b1;
    mul_start = 1'b0;
    sel_len   = 1'b0;
    unique case (state_r)
      gph_pkg::ST_IDLE: begin
        in_stall  = 1'b0;
        mul_start = in_valid;
      end
      gph_pkg::ST_BLOCK: begin
        mul_start = rsp.done && last_r;
        sel_len   = 1'b1;
      end
      gph_pkg::ST_LENGTH: begin
      end
      gph_pkg::ST_DONE: begin
      end
      default: in_stall = 1'b1;
    endcase
  end

  assign mul_x = sel_len ? (rsp.product ^ {64'd0, len_word}) : (acc_r ^ blk);

  always_comb begin
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    sat_nxt  = sat_r;
    last_nxt = last_r;
    ov_nxt   = ov_r && out_stall;
    dhi_nxt  = dhi_r;
    dlo_nxt  = dlo_r;
    ovl_nxt  = ovl_r;
    if (accept) begin
      last_nxt = in_last_block;
      if (sum[CNT_W]) begin
        cnt_nxt = '1;
        sat_nxt = 1'b1;
      end else begin
        cnt_nxt = sum[CNT_W-1:0];
      end
    end
    if (rsp.done) begin
      acc_nxt = rsp.product;
    end
    if (state_r == gph_pkg::ST_DONE && out_free) begin
      dhi_nxt  = acc_r[BW-1 -: 64];
      dlo_nxt  = acc_r[63:0];
      ovl_nxt  = sat_r;
      ov_nxt   = 1'b1;
      acc_nxt  = '0;
      cnt_nxt  = '0;
      sat_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    dhi_r <= dhi_nxt;
    dlo_r <= dlo_nxt;
    ovl_r <= ovl_nxt;
    if (!rst_n) begin
      state_r  <= gph_pkg::ST_IDLE;
      key_hi_r <= '0;
      key_lo_r <= '0;
      acc_r    <= '0;
      cnt_r    <= '0;
      sat_r    <= 1'b0;
      last_r   <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      acc_r   <= acc_nxt;
      cnt_r   <= cnt_nxt;
      sat_r   <= sat_nxt;
      last_r  <= last_nxt;
      ov_r    <= ov_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          gph_pkg::REG_KEY_HI: key_hi_r <= cfg_data;
          gph_pkg::REG_KEY_LO: key_lo_r <= cfg_data;
          default: key_hi_r <= key_hi_r;
        endcase
      end
    end
  end

  assign out_valid           = ov_r;
  assign out_digest_hi       = dhi_r;
  assign out_digest_lo       = dlo_r;
  assign out_length_overflow = ovl_r;

endmodule

[rtl/core/gph_checker.sv]
// gph_checker: port-level assertions for gf128_polynomial_hash, bound to the top level
// depends on gph_pkg
module gph_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [63:0]                    out_digest_hi,
  input logic [63:0]                    out_digest_lo,
  input logic                           out_length_overflow,
  input logic                           cfg_ready,
  input logic [gph_pkg::CFG_IDX_W-1:0]  cfg_index
);

  // a stalled digest holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_digest_hi)
      && $stable(out_digest_lo) && $stable(out_length_overflow))
    else $error("stalled digest changed");

  // one block at a time: the multiplier is busy after a request
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while multiply in flight");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("digest shown after reset");

  // key writes are never held off
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready || cfg_index == gph_pkg::REG_KEY_HI || cfg_index == gph_pkg::REG_KEY_LO
      |-> cfg_ready)
    else $error("cfg write held off");

endmodule

bind gf128_polynomial_hash gph_checker u_gph_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_stall            (in_stall),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_digest_hi       (out_digest_hi),
  .out_digest_lo       (out_digest_lo),
  .out_length_overflow (out_length_overflow),
  .cfg_ready           (cfg_ready),
  .cfg_index           (cfg_index)
);
